/* hdl/pdsc_pkg.sv */
// ----------------------------------------------------------------------------
// pdsc_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package pdsc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int DIV_MAX      = 65535;

    localparam int CH_W    = 2;
    localparam int RATE_W  = 30;
    localparam int CHANS_W = 3;
    localparam int VAL_W   = 30;
    localparam int DVD_W   = 60;
    localparam int DVS_W   = 47;
    localparam int PRE_W   = 17;
    localparam int HALF_W  = 16;

    localparam logic [RATE_W-1:0]  NS_PER_S    = 30'd1000000000;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 30'd100000000;
    localparam logic [CHANS_W-1:0] CHANS_RESET = 3'd4;
    localparam logic [DVS_W-1:0]   PRE_DIVISOR = 47'd65536000000000;

    localparam int W1_ENABLE_BIT = 31;
    localparam int W1_UPDATE_BIT = 30;

    localparam logic [1:0] MODE_CFG = 2'd0;
    localparam logic [1:0] MODE_EN  = 2'd1;
    localparam logic [1:0] MODE_POL = 2'd2;

    localparam logic CFG_RATE  = 1'b0;
    localparam logic CFG_CHANS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MUL_PRATE = 2'd0,
        MUL_DRATE = 2'd1,
        MUL_DIV   = 2'd2,
        MUL_HDIV  = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_PRE   = 2'd0,
        DIV_TICKS = 2'd1,
        DIV_HIGH  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     decode;
        logic     clamp;
        logic     res_set;
        t_status  res_code;
        logic     mul_go;
        t_mul_sel mul_sel;
        logic     save_prate;
        logic     save_drate;
        logic     div_go;
        t_div_sel div_sel;
        logic     pre_init;
        logic     pre_inc;
        logic     take_best;
        logic     commit;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic to_config;
        logic per_bad;
        logic rate_zero;
        logic low_rate;
        logic div_done;
        logic pre_over;
        logic ticks_zero;
        logic ticks_le_pre;
        logic ticks_big;
        logic better;
        logic rem_zero;
        logic found;
        logic out_busy;
    } t_stat;

endpackage

/* hdl/pwm_divider_search_channel_ctrl.sv */
// ----------------------------------------------------------------------------
// pwm_divider_search_channel_ctrl
// per-channel pwm set-up engine with prescaler/divider search
// ----------------------------------------------------------------------------
// requests enter on the input channel (i_in_valid / o_in_ready) and each one
// yields exactly one result beat on the output channel (o_out_valid /
// i_out_ready), in order. one request is worked at a time.
// enable requests, requests rejected at decode and polarity on an unconfigured
// channel go from decode straight to the result. a period/duty set-up runs
// the search loop over up to 65536 prescaler values, using the bit-serial
// divider once per prescaler value tried.
// the result sits in an output register: when the receiver stalls, the
// finished beat holds there and the engine waits before its next result.
// configuration (i_cfg_we, i_cfg_addr, i_cfg_wdata) writes take effect at
// once; index 0 is the counter clock in hertz, index 1 the channels in use.
// synchronous reset restores clock 100 MHz, four channels, and clears all
// per-channel state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pwm_divider_search_channel_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [pdsc_pkg::RATE_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_mode,
    input  logic [pdsc_pkg::CH_W-1:0]    i_channel,
    input  logic [31:0]                  i_period_ns,
    input  logic [31:0]                  i_duty_ns,
    input  logic                         i_flag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [pdsc_pkg::CH_W-1:0]    o_channel_written,
    output logic                         o_write_word0,
    output logic [31:0]                  o_word0,
    output logic                         o_write_word1,
    output logic [31:0]                  o_word1
);

    pdsc_pkg::t_cmd  cmd;
    pdsc_pkg::t_stat stat;

    pdsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    pdsc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_mode            (i_mode),
        .i_channel         (i_channel),
        .i_period_ns       (i_period_ns),
        .i_duty_ns         (i_duty_ns),
        .i_flag            (i_flag),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_channel_written (o_channel_written),
        .o_write_word0     (o_write_word0),
        .o_word0           (o_word0),
        .o_write_word1     (o_write_word1),
        .o_word1           (o_word1)
    );

endmodule

/* hdl/pdsc_div.sv */
// ----------------------------------------------------------------------------
// pdsc_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pdsc_pkg::DVD_W-1:0]  i_dividend,
    input  logic [pdsc_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [pdsc_pkg::DVD_W-1:0]  o_quotient,
    output logic [pdsc_pkg::DVS_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(pdsc_pkg::DVD_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [pdsc_pkg::DVS_W-1:0] r_rem;
    logic [pdsc_pkg::DVD_W-1:0] r_quo;
    logic [pdsc_pkg::DVS_W-1:0] r_dvs;

    logic [pdsc_pkg::DVS_W:0]   trial;
    logic [pdsc_pkg::DVS_W:0]   diff;
    logic                       ge;

    always_comb begin
        trial = {r_rem, r_quo[pdsc_pkg::DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(pdsc_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[pdsc_pkg::DVS_W-1:0] : trial[pdsc_pkg::DVS_W-1:0];
            r_quo <= {r_quo[pdsc_pkg::DVD_W-2:0], ge};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hdl/pdsc_dp.sv */
// ----------------------------------------------------------------------------
// pdsc_dp
// datapath: configuration, channel state, multiplier, divider, result beats
// ----------------------------------------------------------------------------
module pdsc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [pdsc_pkg::RATE_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                    i_mode,
    input  logic [pdsc_pkg::CH_W-1:0]     i_channel,
    input  logic [31:0]                   i_period_ns,
    input  logic [31:0]                   i_duty_ns,
    input  logic                          i_flag,
    input  pdsc_pkg::t_cmd                i_cmd,
    output pdsc_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [pdsc_pkg::CH_W-1:0]     o_channel_written,
    output logic                          o_write_word0,
    output logic [31:0]                   o_word0,
    output logic                          o_write_word1,
    output logic [31:0]                   o_word1
);

    localparam int NCH = pdsc_pkg::NUM_CHANNELS;
    localparam int VW  = pdsc_pkg::VAL_W;

    // configuration
    logic [pdsc_pkg::RATE_W-1:0]  r_rate;
    logic [pdsc_pkg::CHANS_W-1:0] r_chans;

    // per-channel state
    logic [VW-1:0] r_st_per [NCH];
    logic [VW-1:0] r_st_dut [NCH];
    logic [NCH-1:0] r_cfgd;
    logic [NCH-1:0] r_en;
    logic [NCH-1:0] r_inv;
    logic [31:0]   r_shadow [NCH];

    // request and work registers
    logic [1:0]                   r_mode;
    logic [pdsc_pkg::CH_W-1:0]    r_ch;
    logic [31:0]                  r_per;
    logic [31:0]                  r_dut;
    logic                         r_flag;
    logic [VW-1:0]                r_eff;
    logic [pdsc_pkg::DVD_W-1:0]   r_prod;
    logic [pdsc_pkg::DVD_W-1:0]   r_prate;
    logic [pdsc_pkg::DVD_W-1:0]   r_drate;
    logic [pdsc_pkg::PRE_W-1:0]   r_pre;
    logic [pdsc_pkg::HALF_W-1:0]  r_best_pre;
    logic [pdsc_pkg::HALF_W-1:0]  r_best_div;
    logic [pdsc_pkg::DVS_W-1:0]   r_min_rem;
    logic                         r_found;

    pdsc_pkg::t_status            r_res_status;
    logic                         r_res_wr0;
    logic [31:0]                  r_res_w0;
    logic                         r_res_wr1;
    logic [31:0]                  r_res_w1;

    logic                         r_out_valid;
    pdsc_pkg::t_status            r_out_status;
    logic [pdsc_pkg::CH_W-1:0]    r_out_ch;
    logic                         r_out_wr0;
    logic [31:0]                  r_out_w0;
    logic                         r_out_wr1;
    logic [31:0]                  r_out_w1;

    logic                         chan_ok;
    logic [31:0]                  rmw_w1;
    logic [31:0]                  new_w1;
    pdsc_pkg::t_status            dec_status;
    logic                         dec_wr1;
    logic [31:0]                  dec_w1;
    logic [VW-1:0]                dut_c;
    logic [VW-1:0]                mul_a;
    logic [VW-1:0]                mul_b;
    logic [pdsc_pkg::DVD_W-1:0]   div_dvd;
    logic [pdsc_pkg::DVS_W-1:0]   div_dvs;
    logic                         div_busy;
    logic                         div_done;
    logic [pdsc_pkg::DVD_W-1:0]   div_q;
    logic [pdsc_pkg::DVS_W-1:0]   div_r;
    logic [pdsc_pkg::PRE_W-1:0]   hi_lim;
    logic [pdsc_pkg::PRE_W-1:0]   hi;

    assign chan_ok = ({1'b0, r_ch} < r_chans) && (32'(r_ch) < NCH);
    assign rmw_w1  = {r_flag, 1'b1, r_shadow[r_ch][29:0]};
    assign new_w1  = {r_en[r_ch], 1'b1, 14'd0, r_best_pre};
    assign dut_c   = (r_dut > r_per) ? r_per[VW-1:0] : r_dut[VW-1:0];
    assign hi_lim  = {1'b0, r_best_div} + 17'd1;
    assign hi      = (div_q > pdsc_pkg::DVD_W'(hi_lim)) ? hi_lim : div_q[pdsc_pkg::PRE_W-1:0];

    always_comb begin
        dec_status = pdsc_pkg::ST_INVAL;
        dec_wr1    = 1'b0;
        dec_w1     = '0;
        if (chan_ok) begin
            unique case (r_mode)
                pdsc_pkg::MODE_EN: begin
                    if (r_cfgd[r_ch]) begin
                        dec_status = pdsc_pkg::ST_OK;
                        dec_wr1    = 1'b1;
                        dec_w1     = rmw_w1;
                    end
                end
                pdsc_pkg::MODE_POL: begin
                    dec_status = pdsc_pkg::ST_OK;
                end
                default: begin
                    dec_status = pdsc_pkg::ST_INVAL;
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            pdsc_pkg::MUL_PRATE: begin
                mul_a = r_per[VW-1:0];
                mul_b = r_rate;
            end
            pdsc_pkg::MUL_DRATE: begin
                mul_a = r_eff;
                mul_b = r_rate;
            end
            pdsc_pkg::MUL_DIV: begin
                mul_a = pdsc_pkg::NS_PER_S;
                mul_b = VW'(r_pre + 17'd1);
            end
            default: begin
                mul_a = pdsc_pkg::NS_PER_S;
                mul_b = VW'({1'b0, r_best_pre} + 17'd1);
            end
        endcase
    end

    always_comb begin
        case (i_cmd.div_sel)
            pdsc_pkg::DIV_PRE: begin
                div_dvd = r_prate;
                div_dvs = pdsc_pkg::PRE_DIVISOR;
            end
            pdsc_pkg::DIV_TICKS: begin
                div_dvd = r_prate;
                div_dvs = r_prod[pdsc_pkg::DVS_W-1:0];
            end
            default: begin
                div_dvd = r_drate;
                div_dvs = r_prod[pdsc_pkg::DVS_W-1:0];
            end
        endcase
    end

    pdsc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_go),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // configuration and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= pdsc_pkg::RATE_RESET;
            r_chans <= pdsc_pkg::CHANS_RESET;
            r_cfgd  <= '0;
            r_en    <= '0;
            r_inv   <= '0;
            for (int i = 0; i < NCH; i++) begin
                r_st_per[i] <= '0;
                r_st_dut[i] <= '0;
                r_shadow[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    pdsc_pkg::CFG_RATE:  r_rate  <= i_cfg_wdata;
                    pdsc_pkg::CFG_CHANS: r_chans <= i_cfg_wdata[pdsc_pkg::CHANS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.decode && chan_ok) begin
                if (r_mode == pdsc_pkg::MODE_EN && r_cfgd[r_ch]) begin
                    r_shadow[r_ch] <= rmw_w1;
                    r_en[r_ch]     <= r_flag;
                end
                if (r_mode == pdsc_pkg::MODE_POL) begin
                    r_inv[r_ch] <= r_flag;
                end
            end
            if (i_cmd.commit) begin
                r_st_per[r_ch] <= r_per[VW-1:0];
                r_st_dut[r_ch] <= r_dut[VW-1:0];
                r_cfgd[r_ch]   <= 1'b1;
                r_shadow[r_ch] <= new_w1;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_ch   <= i_channel;
            r_per  <= i_period_ns;
            r_dut  <= i_duty_ns;
            r_flag <= i_flag;
        end
        if (i_cmd.decode && o_stat.to_config && r_mode == pdsc_pkg::MODE_POL) begin
            r_per <= {2'b00, r_st_per[r_ch]};
            r_dut <= {2'b00, r_st_dut[r_ch]};
        end
        if (i_cmd.clamp) begin
            r_dut <= {2'b00, dut_c};
            r_eff <= r_inv[r_ch] ? (r_per[VW-1:0] - dut_c) : dut_c;
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.save_prate) begin
            r_prate <= r_prod;
        end
        if (i_cmd.save_drate) begin
            r_drate <= r_prod;
        end
        if (i_cmd.pre_init) begin
            r_pre   <= div_q[pdsc_pkg::PRE_W-1:0];
            r_found <= 1'b0;
        end
        if (i_cmd.pre_inc) begin
            r_pre <= r_pre + 1'b1;
        end
        if (i_cmd.take_best) begin
            r_best_pre <= r_pre[pdsc_pkg::HALF_W-1:0];
            r_best_div <= pdsc_pkg::HALF_W'(div_q - 1'b1);
            r_min_rem  <= div_r;
            r_found    <= 1'b1;
        end
    end

    // result of the current request
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_res_status <= dec_status;
            r_res_wr0    <= 1'b0;
            r_res_w0     <= '0;
            r_res_wr1    <= dec_wr1;
            r_res_w1     <= dec_w1;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_wr0    <= 1'b0;
            r_res_w0     <= '0;
            r_res_wr1    <= 1'b0;
            r_res_w1     <= '0;
        end
        if (i_cmd.commit) begin
            r_res_status <= pdsc_pkg::ST_OK;
            r_res_wr0    <= 1'b1;
            r_res_w0     <= {hi[pdsc_pkg::HALF_W-1:0], r_best_div};
            r_res_wr1    <= 1'b1;
            r_res_w1     <= new_w1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_ch     <= r_ch;
            r_out_wr0    <= r_res_wr0;
            r_out_w0     <= r_res_w0;
            r_out_wr1    <= r_res_wr1;
            r_out_w1     <= r_res_w1;
        end
    end

    always_comb begin
        o_stat.to_config    = chan_ok && (r_mode == pdsc_pkg::MODE_CFG ||
                              (r_mode == pdsc_pkg::MODE_POL && r_cfgd[r_ch]));
        o_stat.per_bad      = (r_per == '0) || (r_per > 32'd1000000000);
        o_stat.rate_zero    = (r_rate == '0);
        o_stat.low_rate     = (r_prate < pdsc_pkg::DVD_W'(pdsc_pkg::NS_PER_S));
        o_stat.div_done     = div_done;
        o_stat.pre_over     = (r_pre > pdsc_pkg::PRE_W'(pdsc_pkg::DIV_MAX));
        o_stat.ticks_zero   = (div_q == '0);
        o_stat.ticks_le_pre = (div_q <= pdsc_pkg::DVD_W'(r_pre));
        o_stat.ticks_big    = (div_q > pdsc_pkg::DVD_W'(pdsc_pkg::DIV_MAX));
        o_stat.better       = !r_found || (div_r < r_min_rem);
        o_stat.rem_zero     = (div_r == '0);
        o_stat.found        = r_found;
        o_stat.out_busy     = r_out_valid && !i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_channel_written = r_out_ch;
    assign o_write_word0     = r_out_wr0;
    assign o_word0           = r_out_w0;
    assign o_write_word1     = r_out_wr1;
    assign o_word1           = r_out_w1;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> !div_busy)
        else $error("divider started while busy");

    a_fail_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != pdsc_pkg::ST_OK) |-> (!r_out_wr0 && !r_out_wr1))
        else $error("failed request carries a write");

    a_word0_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_wr0) |-> r_out_wr1)
        else $error("word0 written without word1");

endmodule

/* hdl/pdsc_ctrl.sv */
// ----------------------------------------------------------------------------
// pdsc_ctrl
// request sequencer: decode, range checks, divider search, result hand-off
// ----------------------------------------------------------------------------
module pdsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output pdsc_pkg::t_cmd   o_cmd,
    input  pdsc_pkg::t_stat  i_stat
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_DECODE = 15'h0002,
        S_CHECK  = 15'h0004,
        S_MULP   = 15'h0008,
        S_MULD   = 15'h0010,
        S_LOW    = 15'h0020,
        S_PREDIV = 15'h0040,
        S_LTOP   = 15'h0080,
        S_LDIV0  = 15'h0100,
        S_LDIV   = 15'h0200,
        S_STEP   = 15'h0400,
        S_END    = 15'h0800,
        S_HDIV0  = 15'h1000,
        S_HDIV   = 15'h2000,
        S_DONE   = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_stat.to_config ? S_CHECK : S_DONE;
            end
            S_CHECK: begin
                if (i_stat.per_bad) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = pdsc_pkg::ST_RANGE;
                    n_state        = S_DONE;
                end else if (i_stat.rate_zero) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = pdsc_pkg::ST_INVAL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.clamp = 1'b1;
                    n_state     = S_MULP;
                end
            end
            S_MULP: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = pdsc_pkg::MUL_PRATE;
                n_state       = S_MULD;
            end
            S_MULD: begin
                o_cmd.save_prate = 1'b1;
                o_cmd.mul_go     = 1'b1;
                o_cmd.mul_sel    = pdsc_pkg::MUL_DRATE;
                n_state          = S_LOW;
            end
            S_LOW: begin
                o_cmd.save_drate = 1'b1;
                if (i_stat.low_rate) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = pdsc_pkg::ST_RANGE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = pdsc_pkg::DIV_PRE;
                    n_state       = S_PREDIV;
                end
            end
            S_PREDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.pre_init = 1'b1;
                    n_state        = S_LTOP;
                end
            end
            S_LTOP: begin
                if (i_stat.pre_over) begin
                    n_state = S_END;
                end else begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = pdsc_pkg::MUL_DIV;
                    n_state       = S_LDIV0;
                end
            end
            S_LDIV0: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = pdsc_pkg::DIV_TICKS;
                n_state       = S_LDIV;
            end
            S_LDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_stat.ticks_zero) begin
                    o_cmd.pre_inc = 1'b1;
                    n_state       = S_LTOP;
                end else if (i_stat.ticks_le_pre) begin
                    n_state = S_END;
                end else if (i_stat.ticks_big) begin
                    o_cmd.pre_inc = 1'b1;
                    n_state       = S_LTOP;
                end else if (i_stat.better) begin
                    o_cmd.take_best = 1'b1;
                    if (i_stat.rem_zero) begin
                        n_state = S_END;
                    end else begin
                        o_cmd.pre_inc = 1'b1;
                        n_state       = S_LTOP;
                    end
                end else begin
                    o_cmd.pre_inc = 1'b1;
                    n_state       = S_LTOP;
                end
            end
            S_END: begin
                if (!i_stat.found) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = pdsc_pkg::ST_RANGE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = pdsc_pkg::MUL_HDIV;
                    n_state       = S_HDIV0;
                end
            end
            S_HDIV0: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = pdsc_pkg::DIV_HIGH;
                n_state       = S_HDIV;
            end
            S_HDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy)
        else $error("result loaded over a pending beat");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result loaded outside request end");

endmodule
